### rtl/boi_pkg.sv
// Shared types and constants for the box overlap score pipeline.
package boi_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int SCORE_FRAC_BITS_DEF = 14;

  // Metric selector carried in the input tuser.
  localparam logic [1:0] CMD_IOU  = 2'd0;
  localparam logic [1:0] CMD_GIOU = 2'd1;
  localparam logic [1:0] CMD_DIOU = 2'd2;

  // Per-item control that travels beside the numerator and denominator.
  typedef struct packed {
    logic neg;
    logic zero_den;
  } boi_ctl_t;

endpackage

### rtl/box_overlap_iou_unit.sv
// Throughput: one transaction per cycle; an item enters every clock while the output drains.
// The depth is set by the restoring divider, one quotient bit per stage, behind eight
// stages of geometry, area products and 2x2 split wide multipliers.
// Reset clears only the stage valid bits; no clearing pass is needed.
module box_overlap_iou_unit #(
  parameter int COORD_BITS      = boi_pkg::COORD_BITS_DEF,
  parameter int SCORE_FRAC_BITS = boi_pkg::SCORE_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // box_a_xmin, box_a_ymin, box_a_xmax, box_a_ymax, box_b_xmin, box_b_ymin,
  // box_b_xmax, box_b_ymax, each COORD_BITS wide, lowest first
  input  logic [((8*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // command
  input  logic [1:0]                              s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // score (signed, SCORE_FRAC_BITS fraction bits)
  output logic [((SCORE_FRAC_BITS+2+7)/8)*8-1:0]  m_axis_tdata,
  // zero_denominator
  output logic [0:0]                              m_axis_tuser
);
  import boi_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int SB  = SCORE_FRAC_BITS + 2;
  localparam int W1  = 2 * C + 3;
  localparam int DW  = 2 * W1;
  localparam int OTW = ((SB + 7) / 8) * 8;

  logic          mid_valid, mid_ready;
  logic [DW:0]   mid_mag;
  logic [DW-1:0] mid_den;
  boi_ctl_t      mid_ctl;
  logic [SB-1:0] score;
  logic          zero_den;

  boi_front #(.C(C)) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_cmd(s_axis_tuser),
    .in_ax0(s_axis_tdata[0*C +: C]),
    .in_ay0(s_axis_tdata[1*C +: C]),
    .in_ax1(s_axis_tdata[2*C +: C]),
    .in_ay1(s_axis_tdata[3*C +: C]),
    .in_bx0(s_axis_tdata[4*C +: C]),
    .in_by0(s_axis_tdata[5*C +: C]),
    .in_bx1(s_axis_tdata[6*C +: C]),
    .in_by1(s_axis_tdata[7*C +: C]),
    .out_valid(mid_valid),
    .out_ready(mid_ready),
    .out_mag(mid_mag),
    .out_den(mid_den),
    .out_ctl(mid_ctl)
  );

  boi_div #(.DW(DW), .FRAC(SCORE_FRAC_BITS)) u_div (
    .clk(clk),
    .rst(rst),
    .in_valid(mid_valid),
    .in_ready(mid_ready),
    .in_mag(mid_mag),
    .in_den(mid_den),
    .in_ctl(mid_ctl),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_score(score),
    .out_zero_den(zero_den)
  );

  assign m_axis_tdata    = OTW'(score);
  assign m_axis_tuser[0] = zero_den;

`ifndef SYNTH
  // A zero denominator always forces the score to zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && zero_den |-> score == '0)
    else $error("score not zero with zero denominator");

  // The score never leaves the range -1.0 .. +1.0.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (score[SB-1:SB-2] != 2'b10) &&
                      (score[SB-1:SB-2] != 2'b01 || score[SB-3:0] == '0))
    else $error("score outside -1.0 .. +1.0");

  // A waiting result holds its value until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(score) && $stable(zero_den))
    else $error("stalled result changed");
`endif

endmodule

### rtl/boi_mul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
module boi_mul #(
  parameter int W = 35
) (
  input  logic           clk,
  input  logic           en_pp,
  input  logic           en_sum,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);
  localparam int H  = (W + 1) / 2;
  localparam int L  = W - H;
  localparam int PW = 2 * W;

  logic [2*H-1:0] pp_ll;
  logic [H+L-1:0] pp_lh;
  logic [H+L-1:0] pp_hl;
  logic [2*L-1:0] pp_hh;

  always_ff @(posedge clk) begin
    if (en_pp) begin
      pp_ll <= a[H-1:0] * b[H-1:0];
      pp_lh <= a[H-1:0] * b[W-1:H];
      pp_hl <= a[W-1:H] * b[H-1:0];
      pp_hh <= a[W-1:H] * b[W-1:H];
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      p <= (PW'(pp_hh) << (2 * H)) + ((PW'(pp_lh) + PW'(pp_hl)) << H) + PW'(pp_ll);
    end
  end

endmodule

### rtl/boi_front.sv
// Geometry, area products and the signed numerator and denominator of the score.
module boi_front #(
  parameter int C = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [C-1:0]                in_ax0,
  input  logic [C-1:0]                in_ay0,
  input  logic [C-1:0]                in_ax1,
  input  logic [C-1:0]                in_ay1,
  input  logic [C-1:0]                in_bx0,
  input  logic [C-1:0]                in_by0,
  input  logic [C-1:0]                in_bx1,
  input  logic [C-1:0]                in_by1,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2*(2*C+3):0]          out_mag,
  output logic [2*(2*C+3)-1:0]        out_den,
  output boi_pkg::boi_ctl_t           out_ctl
);
  import boi_pkg::*;

  localparam int W1 = 2 * C + 3;
  localparam int PW = 2 * W1;
  localparam int NW = PW + 1;
  localparam int NS = 8;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  function automatic logic [C-1:0] span(input logic [C-1:0] lo, input logic [C-1:0] hi);
    return (hi > lo) ? hi - lo : '0;
  endfunction

  // Stage 0: extents and doubled centre offsets.
  logic [1:0]   s0_cmd;
  logic [C-1:0] s0_wa, s0_ha, s0_wb, s0_hb, s0_iw, s0_ih, s0_ew, s0_eh;
  logic [C:0]   s0_dx, s0_dy;

  logic [C:0] sum_ax, sum_bx, sum_ay, sum_by;
  assign sum_ax = (C+1)'(in_ax0) + (C+1)'(in_ax1);
  assign sum_bx = (C+1)'(in_bx0) + (C+1)'(in_bx1);
  assign sum_ay = (C+1)'(in_ay0) + (C+1)'(in_ay1);
  assign sum_by = (C+1)'(in_by0) + (C+1)'(in_by1);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_cmd <= in_cmd;
      s0_wa  <= span(in_ax0, in_ax1);
      s0_ha  <= span(in_ay0, in_ay1);
      s0_wb  <= span(in_bx0, in_bx1);
      s0_hb  <= span(in_by0, in_by1);
      s0_iw  <= span((in_ax0 > in_bx0) ? in_ax0 : in_bx0, (in_ax1 < in_bx1) ? in_ax1 : in_bx1);
      s0_ih  <= span((in_ay0 > in_by0) ? in_ay0 : in_by0, (in_ay1 < in_by1) ? in_ay1 : in_by1);
      s0_ew  <= span((in_ax0 < in_bx0) ? in_ax0 : in_bx0, (in_ax1 > in_bx1) ? in_ax1 : in_bx1);
      s0_eh  <= span((in_ay0 < in_by0) ? in_ay0 : in_by0, (in_ay1 > in_by1) ? in_ay1 : in_by1);
      s0_dx  <= (sum_ax > sum_bx) ? sum_ax - sum_bx : sum_bx - sum_ax;
      s0_dy  <= (sum_ay > sum_by) ? sum_ay - sum_by : sum_by - sum_ay;
    end
  end

  // Stage 1: areas and squares.
  logic [1:0]     s1_cmd;
  logic [2*C-1:0] s1_area_a, s1_area_b, s1_inter, s1_encl, s1_ew2, s1_eh2;
  logic [2*C+1:0] s1_dx2, s1_dy2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_cmd    <= s0_cmd;
      s1_area_a <= s0_wa * s0_ha;
      s1_area_b <= s0_wb * s0_hb;
      s1_inter  <= s0_iw * s0_ih;
      s1_encl   <= s0_ew * s0_eh;
      s1_ew2    <= s0_ew * s0_ew;
      s1_eh2    <= s0_eh * s0_eh;
      s1_dx2    <= s0_dx * s0_dx;
      s1_dy2    <= s0_dy * s0_dy;
    end
  end

  // Stage 2: union, four times the squared diagonal, four times the squared centre distance.
  logic [1:0]     s2_cmd;
  logic [W1-1:0]  s2_uni, s2_diag4, s2_dist2;
  logic [2*C-1:0] s2_inter, s2_encl;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_cmd   <= s1_cmd;
      s2_uni   <= W1'(s1_area_a) + W1'(s1_area_b) - W1'(s1_inter);
      s2_diag4 <= (W1'(s1_ew2) + W1'(s1_eh2)) << 2;
      s2_dist2 <= W1'(s1_dx2) + W1'(s1_dy2);
      s2_inter <= s1_inter;
      s2_encl  <= s1_encl;
    end
  end

  // Stage 3: operands of the three wide products for the chosen metric.
  logic [W1-1:0] m1_c, x_c;
  logic          padd_c, nuse_c;

  always_comb begin
    m1_c   = W1'(1);
    x_c    = '0;
    padd_c = 1'b0;
    nuse_c = 1'b0;
    unique case (s2_cmd)
      CMD_GIOU: begin
        m1_c = W1'(s2_encl);
        if (W1'(s2_encl) >= s2_uni) begin
          x_c    = W1'(s2_encl) - s2_uni;
          nuse_c = 1'b1;
        end else begin
          x_c    = s2_uni - W1'(s2_encl);
          padd_c = 1'b1;
        end
      end
      CMD_DIOU: begin
        m1_c   = s2_diag4;
        x_c    = s2_dist2;
        nuse_c = 1'b1;
      end
      default: begin
        m1_c = W1'(1);
      end
    endcase
  end

  logic [W1-1:0] s3_uni, s3_inter, s3_m1, s3_x;
  logic          s3_zero, s3_padd, s3_nuse;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_uni   <= s2_uni;
      s3_inter <= W1'(s2_inter);
      s3_m1    <= m1_c;
      s3_x     <= x_c;
      s3_zero  <= (s2_uni == '0) || (m1_c == '0);
      s3_padd  <= padd_c;
      s3_nuse  <= nuse_c;
    end
  end

  // Stages 4 and 5: wide products, with control bits alongside.
  logic [PW-1:0] p_main, p_pen, p_den;
  logic          s4_zero, s4_padd, s4_nuse, s5_zero, s5_padd, s5_nuse;

  boi_mul #(.W(W1)) u_mul_main (
    .clk(clk), .en_pp(en[4]), .en_sum(en[5]), .a(s3_inter), .b(s3_m1), .p(p_main)
  );
  boi_mul #(.W(W1)) u_mul_pen (
    .clk(clk), .en_pp(en[4]), .en_sum(en[5]), .a(s3_x), .b(s3_uni), .p(p_pen)
  );
  boi_mul #(.W(W1)) u_mul_den (
    .clk(clk), .en_pp(en[4]), .en_sum(en[5]), .a(s3_uni), .b(s3_m1), .p(p_den)
  );

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_zero <= s3_zero;
      s4_padd <= s3_padd;
      s4_nuse <= s3_nuse;
    end
    if (en[5]) begin
      s5_zero <= s4_zero;
      s5_padd <= s4_padd;
      s5_nuse <= s4_nuse;
    end
  end

  // Stage 6: positive and negative parts.
  logic [NW-1:0] s6_pos;
  logic [PW-1:0] s6_neg, s6_den;
  logic          s6_zero;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_pos  <= NW'(p_main) + (s5_padd ? NW'(p_pen) : '0);
      s6_neg  <= s5_nuse ? p_pen : '0;
      s6_den  <= p_den;
      s6_zero <= s5_zero;
    end
  end

  // Stage 7: sign and magnitude of the numerator.
  logic pos_lt;
  assign pos_lt = s6_pos < NW'(s6_neg);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_mag          <= pos_lt ? NW'(s6_neg) - s6_pos : s6_pos - NW'(s6_neg);
      out_den          <= s6_den;
      out_ctl.neg      <= pos_lt;
      out_ctl.zero_den <= s6_zero;
    end
  end

endmodule

### rtl/boi_div.sv
// Pipelined restoring divider giving the saturated, signed fixed-point score.
module boi_div #(
  parameter int DW   = 70,
  parameter int FRAC = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [DW:0]         in_mag,
  input  logic [DW-1:0]       in_den,
  input  boi_pkg::boi_ctl_t   in_ctl,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FRAC+1:0]     out_score,
  output logic                out_zero_den
);
  import boi_pkg::*;

  localparam int NW = DW + 1;
  localparam int SB = FRAC + 2;
  localparam int NS = FRAC + 2;
  localparam logic [SB-1:0] UNITY = {2'b01, {FRAC{1'b0}}};

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  logic [NW-1:0]   rem   [FRAC+1];
  logic [FRAC-1:0] quo   [FRAC+1];
  logic [DW-1:0]   den_s [FRAC+1];
  logic            sat_s [FRAC+1];
  boi_ctl_t        ctl_s [FRAC+1];

  logic [NW-1:0] trial [FRAC+1];
  logic          ge    [FRAC+1];
  logic [NW-1:0] nrem  [FRAC+1];

  // One quotient bit per stage; the remainder stays below the divisor unless the score saturates.
  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    nrem[0]  = '0;
    for (int k = 1; k <= FRAC; k++) begin
      trial[k] = {rem[k-1][NW-2:0], 1'b0};
      ge[k]    = trial[k] >= {1'b0, den_s[k-1]};
      nrem[k]  = ge[k] ? trial[k] - {1'b0, den_s[k-1]} : trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]   <= in_mag;
      quo[0]   <= '0;
      den_s[0] <= in_den;
      sat_s[0] <= in_mag >= {1'b0, in_den};
      ctl_s[0] <= in_ctl;
    end
    for (int k = 1; k <= FRAC; k++) begin
      if (en[k]) begin
        rem[k]   <= nrem[k];
        quo[k]   <= {quo[k-1][FRAC-2:0], ge[k]};
        den_s[k] <= den_s[k-1];
        sat_s[k] <= sat_s[k-1];
        ctl_s[k] <= ctl_s[k-1];
      end
    end
  end

  logic [SB-1:0] mag_c;
  assign mag_c = sat_s[FRAC] ? UNITY : SB'(quo[FRAC]);

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      if (ctl_s[FRAC].zero_den) begin
        out_score <= '0;
      end else if (ctl_s[FRAC].neg) begin
        out_score <= '0 - mag_c;
      end else begin
        out_score <= mag_c;
      end
      out_zero_den <= ctl_s[FRAC].zero_den;
    end
  end

endmodule
